// ----- rtl/srw_pkg.sv -----
// Shared types and constants for the selective-repeat receive window.
package srw_pkg;

    localparam int WINDOW_DEF   = 32;
    localparam int CAPACITY_DEF = 64;
    localparam int QUEUE_DEPTH  = 2;

    localparam int SEQ_W  = 32;
    localparam int PAY_W  = 64;
    localparam int LEN_W  = 12;
    localparam int PORT_W = 16;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_num;
        logic              check_ok;
        logic [PAY_W-1:0]  payload;
        logic [LEN_W-1:0]  payload_len;
        logic [PORT_W-1:0] reply_port;
    } seg_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_num;
        logic [PAY_W-1:0]  payload;
        logic [LEN_W-1:0]  payload_len;
        logic [PORT_W-1:0] reply_port;
        logic              in_win;
    } cmd_t;

    typedef struct packed {
        logic [SEQ_W-1:0] base;
        logic             full;
        logic             idle;
    } status_t;

endpackage

// ----- rtl/srw_in_if.sv -----
// Segment request channel.
interface srw_in_if;
    import srw_pkg::*;

    logic              valid;
    logic              ready;
    logic [SEQ_W-1:0]  seq_num;
    logic              check_ok;
    logic [PAY_W-1:0]  payload;
    logic [LEN_W-1:0]  payload_len;
    logic [PORT_W-1:0] reply_port;

    modport source (output valid, seq_num, check_ok, payload, payload_len, reply_port,
                    input ready);
    modport sink   (input valid, seq_num, check_ok, payload, payload_len, reply_port,
                    output ready);
endinterface

// ----- rtl/srw_out_if.sv -----
// Result request channel (acks and deliveries).
interface srw_out_if;
    import srw_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [PAY_W-1:0]  out_payload;
    logic [LEN_W-1:0]  out_len;
    logic [PORT_W-1:0] ack_port;
    logic              last;

    modport source (output valid, kind, out_seq, out_payload, out_len, ack_port, last,
                    input ready);
    modport sink   (input valid, kind, out_seq, out_payload, out_len, ack_port, last,
                    output ready);
endinterface

// ----- rtl/srw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/srw_front.sv -----
// Front end: drops bad, beyond-window or store-full segment requests; queues the rest.
module srw_front #(
    parameter int WINDOW = srw_pkg::WINDOW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    srw_in_if.sink           seg,
    input  srw_pkg::status_t stat,
    output logic             push,
    output srw_pkg::cmd_t    push_cmd
);
    import srw_pkg::*;

    seg_t             hold_reg;
    logic             hold_valid_reg;
    logic             accept;
    logic [SEQ_W:0]   win_top;
    logic             beyond;
    logic             drop;

    assign seg.ready = !hold_valid_reg && stat.idle;
    assign accept    = seg.valid && seg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg.seq_num     <= seg.seq_num;
            hold_reg.check_ok    <= seg.check_ok;
            hold_reg.payload     <= seg.payload;
            hold_reg.payload_len <= seg.payload_len;
            hold_reg.reply_port  <= seg.reply_port;
        end
    end

    // unwrapped window bound
    assign win_top = {1'b0, stat.base} + (SEQ_W+1)'(WINDOW);
    assign beyond  = {1'b0, hold_reg.seq_num} > win_top;
    assign drop    = !hold_reg.check_ok || stat.full || beyond;

    assign push                 = hold_valid_reg && !drop;
    assign push_cmd.seq_num     = hold_reg.seq_num;
    assign push_cmd.payload     = hold_reg.payload;
    assign push_cmd.payload_len = hold_reg.payload_len;
    assign push_cmd.reply_port  = hold_reg.reply_port;
    assign push_cmd.in_win      = hold_reg.seq_num >= stat.base;
endmodule

// ----- rtl/srw_fifo.sv -----
// Short command queue between front end and back end.
module srw_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  srw_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          pop_valid,
    output srw_pkg::cmd_t pop_cmd
);
    import srw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic             do_pop;

    assign pop_valid = count_reg != '0;
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

// ----- rtl/srw_back.sv -----
// Back end: slot store, window state, ack and in-order drain.
module srw_back #(
    parameter int WINDOW   = srw_pkg::WINDOW_DEF,
    parameter int CAPACITY = srw_pkg::CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    input  srw_pkg::cmd_t    pop_cmd,
    output logic             pop,
    output srw_pkg::status_t stat,
    srw_out_if.source        res
);
    import srw_pkg::*;

    localparam int OFF_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (OFF_W + 1 > OCC_W) ? OFF_W + 1 : OCC_W;
    localparam int SUM_W  = CMP_W + 1;
    localparam int SLOT_W = LEN_W + PAY_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ACK   = 3'b010,
        ST_DELIV = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [CAPACITY-1:0] recv_reg, recv_next;
    logic [SEQ_W-1:0]   ack_seq_reg;
    logic [PORT_W-1:0]  ack_port_reg;

    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg;
    logic [SEQ_W-1:0]   out_seq_reg;
    logic [PAY_W-1:0]   out_pay_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [PORT_W-1:0]  out_port_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               load_ack;
    logic               load_deliv;
    logic               more_ack;
    logic               more_deliv;
    logic [IDX_W-1:0]   head_inc;
    logic [SEQ_W-1:0]   diff;
    logic [OFF_W-1:0]   off;
    logic [CMP_W-1:0]   off_x;
    logic [CMP_W-1:0]   off_p1;
    logic [CMP_W-1:0]   occ_x;
    logic [CMP_W-1:0]   cap_x;
    logic [CMP_W-1:0]   open_occ;
    logic [CMP_W-1:0]   occ_after;
    logic               placed;
    logic [SUM_W-1:0]   slot_sum;
    logic [SUM_W-1:0]   slot_wrap;
    logic [IDX_W-1:0]   slot;
    logic               we;
    logic [IDX_W-1:0]   raddr;
    logic [SLOT_W-1:0]  rdata;

    assign out_free = !out_valid_reg || res.ready;
    assign pop      = (state_reg == ST_IDLE) && pop_valid;

    assign stat.base = base_reg;
    assign stat.full = occ_reg == OCC_W'(CAPACITY);
    assign stat.idle = (state_reg == ST_IDLE) && !pop_valid;

    // placement
    assign diff      = pop_cmd.seq_num - base_reg;
    assign off       = diff[OFF_W-1:0];
    assign off_x     = CMP_W'(off);
    assign off_p1    = off_x + 1'b1;
    assign occ_x     = CMP_W'(occ_reg);
    assign cap_x     = CMP_W'(CAPACITY);
    assign placed    = off_x < cap_x;
    assign open_occ  = (off_p1 > cap_x) ? cap_x : off_p1;
    assign occ_after = (off_x < occ_x) ? occ_x : open_occ;
    assign slot_sum  = SUM_W'(head_reg) + SUM_W'(off);
    assign slot_wrap = (slot_sum >= SUM_W'(CAPACITY)) ? slot_sum - SUM_W'(CAPACITY)
                                                      : slot_sum;
    assign slot      = slot_wrap[IDX_W-1:0];
    assign we        = pop && pop_cmd.in_win && placed && !recv_reg[slot];

    // drain
    assign head_inc   = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign more_ack   = (occ_reg != '0) && recv_reg[head_reg];
    assign more_deliv = (occ_reg != OCC_W'(1)) && recv_reg[head_inc];
    assign load_ack   = (state_reg == ST_ACK) && out_free;
    assign load_deliv = (state_reg == ST_DELIV) && out_free;
    assign raddr      = load_deliv ? head_inc : head_reg;

    srw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (slot),
        .wdata ({pop_cmd.payload_len, pop_cmd.payload}),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        head_next  = head_reg;
        occ_next   = occ_reg;
        recv_next  = recv_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_ACK;
                    if (pop_cmd.in_win)
                    begin
                        occ_next = occ_after[OCC_W-1:0];
                    end
                    if (we)
                    begin
                        recv_next[slot] = 1'b1;
                    end
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    state_next = more_ack ? ST_DELIV : ST_IDLE;
                end
            end
            ST_DELIV:
            begin
                if (out_free)
                begin
                    recv_next[head_reg] = 1'b0;
                    head_next           = head_inc;
                    occ_next            = occ_reg - 1'b1;
                    base_next           = base_reg + 1'b1;
                    state_next          = more_deliv ? ST_DELIV : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_ack || load_deliv)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            head_reg      <= '0;
            occ_reg       <= '0;
            recv_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            recv_reg      <= recv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ack_seq_reg  <= pop_cmd.seq_num;
            ack_port_reg <= pop_cmd.reply_port;
        end
        if (load_ack)
        begin
            out_kind_reg <= KIND_ACK;
            out_seq_reg  <= ack_seq_reg;
            out_pay_reg  <= '0;
            out_len_reg  <= '0;
            out_port_reg <= ack_port_reg;
            out_last_reg <= !more_ack;
        end
        else if (load_deliv)
        begin
            out_kind_reg <= KIND_DELIVER;
            out_seq_reg  <= base_reg;
            out_pay_reg  <= rdata[PAY_W-1:0];
            out_len_reg  <= rdata[SLOT_W-1:PAY_W];
            out_port_reg <= '0;
            out_last_reg <= !more_deliv;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.kind        = out_kind_reg;
    assign res.out_seq     = out_seq_reg;
    assign res.out_payload = out_pay_reg;
    assign res.out_len     = out_len_reg;
    assign res.ack_port    = out_port_reg;
    assign res.last        = out_last_reg;
endmodule

// ----- rtl/selective_repeat_receive_window.sv -----
// Top level of the selective-repeat receive window.
//
//  channel | dir | handshake     | carries
//  seg     | in  | valid / ready | seq_num, check_ok, payload, payload_len, reply_port
//  res     | out | valid / ready | kind, out_seq, out_payload, out_len, ack_port, last
//
// A segment is queued, popped by the back-end sequencer, acked and followed by any
// in-order deliveries before the next one can be taken; the back-end sequencer handles one segment at
// a time and the slot RAM gives one delivery per cycle while res is not stalled.
// Dropped segments free the input once the front-end holding register clears.
// Reset is asynchronous, active low; slot contents are not cleared.
// A stalled res holds the sequencer; the input stays closed until it is done.
module selective_repeat_receive_window #(
    parameter int WINDOW   = srw_pkg::WINDOW_DEF,
    parameter int CAPACITY = srw_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    srw_in_if.sink    seg,
    srw_out_if.source res
);
    import srw_pkg::*;

    status_t stat;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    logic    pop_valid;
    cmd_t    pop_cmd;

    srw_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .seg      (seg),
        .stat     (stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    srw_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    srw_back #(
        .WINDOW   (WINDOW),
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .stat      (stat),
        .res       (res)
    );
endmodule

// ----- rtl/srw_checker.sv -----
// Port-level checks for the selective-repeat receive window, with bind.
module srw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        seg_valid,
    input logic        seg_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_last,
    input logic [31:0] res_seq
);
    // no new segment while results of the current one are still coming
    a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !seg_ready)
        else $error("segment input open during a result burst");

    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready |=> !seg_ready)
        else $error("input stayed open after a request");

    // the ack must not appear before the segment has passed the front end and queue
    a_ack_latency: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready |-> ##2 !$rose(res_valid))
        else $error("result appeared too early");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_seq) && $stable(res_last))
        else $error("stalled result changed");
endmodule

bind selective_repeat_receive_window srw_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_valid (seg.valid),
    .seg_ready (seg.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_last  (res.last),
    .res_seq   (res.out_seq)
);
